### sv/prap_pkg.sv
// ----------------------------------------------------------------------------
// prap_pkg: shared types and constants of the passive reply address parser
// Character classes, queue item and status, parser phase and token codes, status codes, result.
// ----------------------------------------------------------------------------
package prap_pkg;

  localparam int unsigned NUM_COUNT = 6;   // numbers in a reply
  localparam int unsigned CAP_DEPTH = 5;   // numbers held apart from the accumulator
  localparam int unsigned ACC_W     = 9;   // accumulator, saturates at ACC_CAP
  localparam logic [ACC_W-1:0] ACC_CAP = 9'd256;
  localparam logic [11:0] BYTE_MAX = 12'd255;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_OPEN  = 8'h28;
  localparam logic [7:0] CHAR_CLOSE = 8'h29;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [3:0] {
    CLS_NUL,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_COMMA,
    CLS_BLANK,
    CLS_PLUS,
    CLS_MINUS,
    CLS_DIGIT,
    CLS_OTHER
  } char_class_e;

  typedef struct packed {
    char_class_e cls;
    logic [3:0]  digit;
    logic        last;
  } item_t;

  typedef struct packed {
    logic valid;  // queue holds at least one item
    logic full;   // queue cannot take an item this cycle
  } queue_status_t;

  typedef enum logic [1:0] {
    PH_SEEK,
    PH_COLLECT,
    PH_CLOSED,
    PH_DEAD
  } phase_e;

  typedef enum logic [1:0] {
    TM_BETWEEN,
    TM_BLANKS,
    TM_DIGITS,
    TM_SKIP
  } token_mode_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NO_PAREN,
    ST_FEW_NUMBERS,
    ST_RANGE
  } status_e;

  typedef struct packed {
    logic [15:0] port;
    logic [7:0]  addr_3;
    logic [7:0]  addr_2;
    logic [7:0]  addr_1;
    logic [7:0]  addr_0;
    status_e     status;
  } result_t;

endpackage

### sv/passive_reply_address_parser.sv
// ----------------------------------------------------------------------------
// passive_reply_address_parser: passive-mode reply address parser
// Path: an accepted byte is written into the queue and executed from its
//   head; the result of a last byte goes to the output register when executed.
// Throughput: one byte per cycle, set by the execute stage; a last byte
//   waits at the queue head only while an earlier result is untaken.
// Reset: rst_ni clears queue, parser state and output valid; the block takes
//   a byte as soon as reset is released.
// ----------------------------------------------------------------------------
module passive_reply_address_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // last byte of the reply
  // parsed result
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // [1:0] status, [9:2] addr_0, [17:10] addr_1,
                                      // [25:18] addr_2, [33:26] addr_3,
                                      // [49:34] port, [55:50] zero
);
  import prap_pkg::*;

  item_t         cls_item;
  item_t         head_item;
  queue_status_t queue_status;
  logic          push;
  logic          pop;
  result_t       result;

  // Front: classify every byte and queue it; the queue only refuses when
  // both entries are taken, so bytes stream in while the back end drains.
  prap_classify u_classify (
    .in_byte_i (s_axis_tdata),
    .last_i    (s_axis_tlast),
    .item_o    (cls_item)
  );

  assign s_axis_tready = !queue_status.full;
  assign push          = s_axis_tvalid && s_axis_tready;

  prap_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (cls_item),
    .pop_i    (pop),
    .item_o   (head_item),
    .status_o (queue_status)
  );

  // Back: token state machine plus output register. Non-last items keep
  // flowing even while a finished result waits downstream.
  prap_exec u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (head_item),
    .queue_i     (queue_status),
    .pop_o       (pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (result)
  );

  assign m_axis_tdata = {6'b0, result};

  // a refused byte means the queue really holds items
  a_refuse_only_when_queued: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !s_axis_tready |-> queue_status.valid
  ) else $error("input refused with an empty queue");

  // address and port are zero unless the reply parsed cleanly
  a_fields_zero_on_error: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && result.status != ST_OK) |-> (m_axis_tdata[49:2] == '0)
  ) else $error("result fields nonzero with error status");

  // a last item never overwrites an untaken result
  a_no_result_overwrite: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (pop && head_item.last) |-> (!m_axis_tvalid || m_axis_tready)
  ) else $error("result overwritten before it was taken");

endmodule

### sv/prap_classify.sv
// ----------------------------------------------------------------------------
// prap_classify: character classifier
// Maps one reply byte to its class and digit value for the queue.
// ----------------------------------------------------------------------------
module prap_classify (
  input  logic [7:0]      in_byte_i,
  input  logic            last_i,
  output prap_pkg::item_t item_o
);
  import prap_pkg::*;

  char_class_e cls;

  always_comb begin
    priority if (in_byte_i == CHAR_NUL) begin
      cls = CLS_NUL;
    end else if (in_byte_i == CHAR_OPEN) begin
      cls = CLS_OPEN;
    end else if (in_byte_i == CHAR_CLOSE) begin
      cls = CLS_CLOSE;
    end else if (in_byte_i == CHAR_COMMA) begin
      cls = CLS_COMMA;
    end else if (in_byte_i == CHAR_SPACE ||
                 (in_byte_i >= CHAR_TAB && in_byte_i <= CHAR_CR)) begin
      cls = CLS_BLANK;
    end else if (in_byte_i == CHAR_PLUS) begin
      cls = CLS_PLUS;
    end else if (in_byte_i == CHAR_MINUS) begin
      cls = CLS_MINUS;
    end else if (in_byte_i >= CHAR_ZERO && in_byte_i <= CHAR_NINE) begin
      cls = CLS_DIGIT;
    end else begin
      cls = CLS_OTHER;
    end
  end

  assign item_o.cls   = cls;
  assign item_o.digit = in_byte_i[3:0];  // '0'..'9' carry the value in the low nibble
  assign item_o.last  = last_i;

endmodule

### sv/prap_fifo.sv
// ----------------------------------------------------------------------------
// prap_fifo: two-entry item queue
// Decouples the classifier from the execute stage; push and pop may coincide.
// ----------------------------------------------------------------------------
module prap_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  prap_pkg::item_t         item_i,
  input  logic                    pop_i,
  output prap_pkg::item_t         item_o,
  output prap_pkg::queue_status_t status_o
);
  import prap_pkg::*;

  item_t       mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o         = mem_q[rd_ptr_q];
  assign status_o.valid = (count_q != 2'd0);
  assign status_o.full  = count_q[1];

endmodule

### sv/prap_exec.sv
// ----------------------------------------------------------------------------
// prap_exec: reply parser execute stage
// Runs the token state machine on one classified item per cycle unless a
// last item waits, as the output register holds a result until it is taken.
// ----------------------------------------------------------------------------
module prap_exec (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  prap_pkg::item_t         item_i,
  input  prap_pkg::queue_status_t queue_i,
  output logic                    pop_o,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output prap_pkg::result_t       res_o
);
  import prap_pkg::*;

  typedef struct packed {
    phase_e                         ph;
    logic [2:0]                     fc;
    token_mode_e                    tm;
    logic [ACC_W-1:0]               acc;
    logic                           err;
    logic [CAP_DEPTH-1:0][7:0]      cap;
  } ctx_t;

  // end of a token: store it, or keep the sixth number in the accumulator
  function automatic ctx_t finish(ctx_t c);
    ctx_t r;
    r = c;
    if (c.fc < 3'(NUM_COUNT - 1)) begin
      r.cap[c.fc] = c.acc[7:0];
      r.fc        = c.fc + 3'd1;
      r.acc       = '0;
    end else begin
      r.fc = 3'(NUM_COUNT);
      r.ph = PH_CLOSED;
    end
    r.tm = TM_BETWEEN;
    return r;
  endfunction

  function automatic ctx_t add_digit(ctx_t c, logic [3:0] d);
    ctx_t        r;
    logic [11:0] v;
    r = c;
    v = 12'(c.acc) * 12'd10 + 12'(d);
    if (v > BYTE_MAX) begin
      r.err = 1'b1;
      r.acc = ACC_CAP;
    end else begin
      r.acc = v[ACC_W-1:0];
    end
    return r;
  endfunction

  phase_e                    ph_q;
  logic [2:0]                fc_q;
  token_mode_e               tm_q;
  logic [ACC_W-1:0]          acc_q;
  logic                      err_q;
  logic [CAP_DEPTH-1:0][7:0] cap_q;
  ctx_t                      cur, nxt;

  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;
  logic    take_last;

  assign cur = '{ph: ph_q, fc: fc_q, tm: tm_q, acc: acc_q, err: err_q, cap: cap_q};

  // a last item waits while an untaken result blocks the output register
  assign pop_o     = queue_i.valid && (!item_i.last || !out_valid_q || res_ready_i);
  assign take_last = pop_o && item_i.last;

  // next state of the token machine
  always_comb begin
    nxt = cur;
    unique case (cur.ph)
      PH_SEEK: begin
        if (item_i.cls == CLS_NUL) begin
          nxt.ph = PH_DEAD;
        end else if (item_i.cls == CLS_OPEN) begin
          nxt.ph = PH_COLLECT;
        end
      end
      PH_COLLECT: begin
        unique case (item_i.cls)
          CLS_NUL, CLS_CLOSE: begin
            if (cur.tm != TM_BETWEEN) begin
              nxt = finish(cur);
            end
            nxt.ph = PH_CLOSED;
          end
          CLS_COMMA: begin
            if (cur.tm != TM_BETWEEN) begin
              nxt = finish(cur);
            end
          end
          default: begin
            unique case (cur.tm)
              TM_BETWEEN, TM_BLANKS: begin
                unique case (item_i.cls)
                  CLS_BLANK: nxt.tm = TM_BLANKS;
                  CLS_PLUS:  nxt.tm = TM_DIGITS;
                  CLS_MINUS: begin
                    nxt.err = 1'b1;
                    nxt.tm  = TM_DIGITS;
                  end
                  CLS_DIGIT: begin
                    nxt    = add_digit(cur, item_i.digit);
                    nxt.tm = TM_DIGITS;
                  end
                  default:   nxt.tm = TM_SKIP;
                endcase
              end
              TM_DIGITS: begin
                if (item_i.cls == CLS_DIGIT) begin
                  nxt = add_digit(cur, item_i.digit);
                end else begin
                  nxt.tm = TM_SKIP;
                end
              end
              TM_SKIP: ;
              default: ;
            endcase
          end
        endcase
      end
      PH_CLOSED, PH_DEAD: ;
      default: ;
    endcase
    // text ends inside a token
    if (item_i.last && nxt.ph == PH_COLLECT && nxt.tm != TM_BETWEEN) begin
      nxt = finish(nxt);
    end
  end

  // result formation and output register
  always_comb begin
    out_d = out_q;
    if (take_last) begin
      priority if (nxt.ph == PH_SEEK || nxt.ph == PH_DEAD) begin
        out_d.status = ST_NO_PAREN;
      end else if (nxt.fc < 3'(NUM_COUNT)) begin
        out_d.status = ST_FEW_NUMBERS;
      end else if (nxt.err) begin
        out_d.status = ST_RANGE;
      end else begin
        out_d.status = ST_OK;
      end
      if (out_d.status == ST_OK) begin
        out_d.addr_0 = nxt.cap[0];
        out_d.addr_1 = nxt.cap[1];
        out_d.addr_2 = nxt.cap[2];
        out_d.addr_3 = nxt.cap[3];
        out_d.port   = {nxt.cap[4], nxt.acc[7:0]};
      end else begin
        out_d.addr_0 = '0;
        out_d.addr_1 = '0;
        out_d.addr_2 = '0;
        out_d.addr_3 = '0;
        out_d.port   = '0;
      end
    end
    if (take_last) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= PH_SEEK;
      fc_q        <= '0;
      tm_q        <= TM_BETWEEN;
      acc_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take_last) begin
        ph_q  <= PH_SEEK;
        fc_q  <= '0;
        tm_q  <= TM_BETWEEN;
        acc_q <= '0;
        err_q <= 1'b0;
      end else if (pop_o) begin
        ph_q  <= nxt.ph;
        fc_q  <= nxt.fc;
        tm_q  <= nxt.tm;
        acc_q <= nxt.acc;
        err_q <= nxt.err;
      end
    end
  end

  // captured numbers are only read once all five are written in this reply
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cap_q <= nxt.cap;
    end
    out_q <= out_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule
